// File: hw/rtl/kpi_pkg.sv
`default_nettype none
package kpi_pkg;
    localparam int KEYS = 16;
    localparam int FRAC_BITS = 16;
    localparam int NCOMP = 9;
    localparam int IDX_W = $clog2(KEYS);
    localparam int CNT_W = $clog2(KEYS + 1);
    localparam int T_W = FRAC_BITS + 1;

    localparam logic [2:0] K_TICK = 3'd0;
    localparam logic [2:0] K_INSERT = 3'd1;
    localparam logic [2:0] K_SETSTART = 3'd2;
    localparam logic [2:0] K_DELETE = 3'd3;
    localparam logic [2:0] K_CLEAR = 3'd4;
    localparam logic [2:0] K_START = 3'd5;
    localparam logic [2:0] K_PAUSE = 3'd6;
    localparam logic [2:0] K_RESET = 3'd7;

    localparam logic [1:0] ST_FINISHED = 2'd0;
    localparam logic [1:0] ST_PLAYING = 2'd1;
    localparam logic [1:0] ST_PAUSED = 2'd2;

    typedef logic signed [31:0] t_comp;
    typedef t_comp [NCOMP-1:0] t_pose;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_SHIFT = 8'b0000_0100,
        S_RDA   = 8'b0000_1000,
        S_RDB   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_LERP  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [T_W-1:0] t;
    } t_lane_req;
endpackage
`default_nettype wire

// File: hw/rtl/kpi_div.sv
`default_nettype none
module kpi_div import kpi_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic [16:0] i_num,
    input  wire logic [16:0] i_den,
    output logic o_done,
    output logic [T_W-1:0] o_t
);
    localparam int NW = 17 + FRAC_BITS;
    localparam int SW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [17:0] r_rem, n_rem;
    logic [16:0] r_den;
    logic [SW-1:0] r_cnt;
    logic r_busy;
    logic [17:0] w_trial;

    always_comb begin
        w_trial = {r_rem[16:0], r_q[NW-1]};
        n_q = {r_q[NW-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= {i_num, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= SW'(NW);
            end else if (r_busy) begin
                r_q <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // The quotient is clamped to one; i never exceeds d whenever the result is used.
    assign o_t = (r_q > NW'(1 << FRAC_BITS)) ? T_W'(1 << FRAC_BITS) : r_q[T_W-1:0];
endmodule
`default_nettype wire

// File: hw/rtl/kpi_lane.sv
`default_nettype none
module kpi_lane import kpi_pkg::*; (
    input  wire logic i_clk,
    input  wire t_lane_req i_req,
    output t_comp o_res
);
    logic signed [32:0] r_diff;
    logic signed [31:0] r_a;
    logic [T_W-1:0] r_t;
    logic signed [50:0] r_prod;
    logic signed [31:0] r_a2;
    logic signed [50:0] w_shift;

    always_ff @(posedge i_clk) begin
        r_diff <= 33'(i_req.b) - 33'(i_req.a);
        r_a <= i_req.a;
        r_t <= i_req.t;
        r_prod <= 51'(r_diff * $signed({1'b0, r_t}));
        r_a2 <= r_a;
    end

    // Arithmetic shift floors towards minus infinity.
    assign w_shift = r_prod >>> FRAC_BITS;
    assign o_res = 32'(51'(r_a2) + w_shift);
endmodule
`default_nettype wire

// File: hw/rtl/keyframe_pose_interpolator_top.sv
`default_nettype none
// A tick that interpolates has its result valid after a 33-step serial divide, two table
// reads and a two-stage multiply in nine lanes. Insert and delete move table rows one per
// cycle. Only one request is handled at a time: the next is accepted only once the
// result has been taken.
// Reset is synchronous and active low; it empties the table and clears the poses.
module keyframe_pose_interpolator_top import kpi_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_ready,
    input  wire logic [2:0] i_kind,
    input  wire logic [15:0] i_key_frame_number,
    input  wire logic [3:0] i_delete_index,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_scale_x,
    input  wire logic signed [31:0] i_scale_y,
    input  wire logic signed [31:0] i_scale_z,
    input  wire logic signed [31:0] i_rot_x,
    input  wire logic signed [31:0] i_rot_y,
    input  wire logic signed [31:0] i_rot_z,
    output logic o_valid,
    input  wire logic i_ready,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_scale_x,
    output logic signed [31:0] o_out_scale_y,
    output logic signed [31:0] o_out_scale_z,
    output logic signed [31:0] o_out_rot_x,
    output logic signed [31:0] o_out_rot_y,
    output logic signed [31:0] o_out_rot_z,
    output logic [1:0] o_anim_status,
    output logic o_pose_written,
    output logic o_rejected
);
    t_state r_state;
    logic [2:0] r_kind;
    logic [15:0] r_kf;
    logic [IDX_W-1:0] r_di;
    t_pose r_comp;

    logic [15:0] r_frames [KEYS];
    t_pose r_mem [KEYS];
    t_pose r_rd;

    logic [CNT_W-1:0] r_count;
    t_pose r_start, r_held, r_pa;
    logic [15:0] r_fc;
    logic [IDX_W-1:0] r_tgt;
    logic r_prev_start;
    logic [1:0] r_play;
    logic r_wrote, r_rej;
    logic [CNT_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_rdaddr;
    logic [2:0] r_wait;
    logic [16:0] r_i, r_d;
    logic r_dstart, r_tzero, r_tone;
    logic [T_W-1:0] r_t;

    logic w_ddone;
    logic [T_W-1:0] w_dt;
    t_lane_req w_req [NCOMP];
    t_comp w_res [NCOMP];
    logic w_acc;
    logic [IDX_W-1:0] w_ptr;
    logic [15:0] w_pf, w_cf;

    assign w_acc = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign w_ptr = r_ptr[IDX_W-1:0];
    assign w_cf = r_frames[r_tgt];
    assign w_pf = (r_prev_start || r_tgt == '0) ? 16'd0 : r_frames[r_tgt - 1'b1];

    kpi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_i), .i_den(r_d), .o_done(w_ddone), .o_t(w_dt)
    );

    for (genvar g = 0; g < NCOMP; g++) begin : g_lane
        assign w_req[g] = '{a: r_pa[g], b: r_rd[g], t: r_t};
        kpi_lane u_lane (.i_clk(i_clk), .i_req(w_req[g]), .o_res(w_res[g]));
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_rdaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_start <= '0;
            r_held <= '0;
            r_fc <= '0;
            r_tgt <= '0;
            r_prev_start <= 1'b1;
            r_play <= ST_FINISHED;
            o_valid <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_kind <= i_kind;
                        r_kf <= i_key_frame_number;
                        r_di <= IDX_W'(i_delete_index);
                        r_comp <= {i_rot_z, i_rot_y, i_rot_x, i_scale_z, i_scale_y,
                                   i_scale_x, i_pos_z, i_pos_y, i_pos_x};
                        r_wrote <= 1'b0;
                        r_rej <= 1'b0;
                        r_ptr <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_OUT;
                    case (r_kind)
                        K_TICK: begin
                            if (r_play == ST_PLAYING) begin
                                if (CNT_W'(r_tgt) >= r_count) begin
                                    r_play <= ST_FINISHED;
                                    r_fc <= r_fc + 1'b1;
                                end else if (r_fc < w_cf) begin
                                    r_i <= 17'(r_fc) - 17'(w_pf);
                                    r_d <= 17'(w_cf) - 17'(w_pf) - 17'd1;
                                    r_tone <= (17'(w_cf) - 17'(w_pf)) <= 17'd1;
                                    r_tzero <= r_fc < w_pf;
                                    r_rdaddr <= r_tgt - 1'b1;
                                    r_state <= S_RDA;
                                end else begin
                                    if (CNT_W'(r_tgt) + 1'b1 < r_count) begin
                                        r_prev_start <= 1'b0;
                                        r_tgt <= r_tgt + 1'b1;
                                    end else begin
                                        r_play <= ST_FINISHED;
                                    end
                                    r_fc <= r_fc + 1'b1;
                                end
                            end
                        end
                        K_INSERT: begin
                            if (r_count >= CNT_W'(KEYS)) begin
                                r_rej <= 1'b1;
                            end else if (r_ptr < r_count && r_frames[w_ptr] <= r_kf) begin
                                r_ptr <= r_ptr + 1'b1;
                                r_state <= S_SCAN;
                            end else begin
                                r_di <= r_count[IDX_W-1:0];
                                r_state <= S_SHIFT;
                            end
                        end
                        K_SETSTART: r_start <= r_comp;
                        K_DELETE: begin
                            if (CNT_W'(r_di) >= r_count) begin
                                r_rej <= 1'b1;
                            end else begin
                                r_state <= S_SHIFT;
                            end
                        end
                        K_CLEAR: r_count <= '0;
                        K_START: begin
                            if (r_count >= CNT_W'(2) && r_play == ST_FINISHED) begin
                                r_tgt <= '0;
                                r_prev_start <= 1'b1;
                                r_fc <= '0;
                                r_play <= ST_PLAYING;
                            end else if (r_play == ST_PAUSED) begin
                                r_play <= ST_PLAYING;
                            end
                        end
                        K_PAUSE: r_play <= ST_PAUSED;
                        default: begin
                            r_fc <= '0;
                            r_tgt <= '0;
                            r_prev_start <= 1'b1;
                            r_held <= r_start;
                            r_wrote <= 1'b1;
                            r_play <= ST_FINISHED;
                        end
                    endcase
                end
                S_SHIFT: begin
                    // Rows move one per cycle; r_di walks to the new slot or the tail.
                    if (r_kind == K_INSERT) begin
                        if (CNT_W'(r_di) == r_ptr) begin
                            r_frames[r_di] <= r_kf;
                            r_mem[r_di] <= r_comp;
                            r_count <= r_count + 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_frames[r_di] <= r_frames[r_di - 1'b1];
                            r_mem[r_di] <= r_mem[r_di - 1'b1];
                            r_di <= r_di - 1'b1;
                        end
                    end else begin
                        if (CNT_W'(r_di) + 1'b1 >= r_count) begin
                            r_count <= r_count - 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_frames[r_di] <= r_frames[r_di + 1'b1];
                            r_mem[r_di] <= r_mem[r_di + 1'b1];
                            r_di <= r_di + 1'b1;
                        end
                    end
                end
                S_RDA: begin
                    r_rdaddr <= r_tgt;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_pa <= (r_prev_start || r_tgt == '0) ? r_start : r_rd;
                    r_dstart <= 1'b1;
                    r_wait <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_t <= r_tone ? T_W'(1 << FRAC_BITS) : (r_tzero ? '0 : w_dt);
                        r_state <= S_LERP;
                    end
                end
                S_LERP: begin
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == 3'd2) begin
                        for (int k = 0; k < NCOMP; k++) begin
                            r_held[k] <= w_res[k];
                        end
                        r_wrote <= 1'b1;
                        r_fc <= r_fc + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_pos_x = r_held[0];
    assign o_out_pos_y = r_held[1];
    assign o_out_pos_z = r_held[2];
    assign o_out_scale_x = r_held[3];
    assign o_out_scale_y = r_held[4];
    assign o_out_scale_z = r_held[5];
    assign o_out_rot_x = r_held[6];
    assign o_out_rot_y = r_held[7];
    assign o_out_rot_z = r_held[8];
    assign o_anim_status = r_play;
    assign o_pose_written = r_wrote;
    assign o_rejected = r_rej;

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(KEYS)) else $error("key count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_rej_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rejected && o_pose_written)) else $error("reject with pose");
`endif
endmodule
`default_nettype wire

// File: test/keyframe_pose_checker.sv
module keyframe_pose_checker import kpi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_ready,
    input  logic [2:0] i_kind,
    input  logic [15:0] i_key_frame_number,
    input  logic [3:0] i_delete_index,
    input  t_pose i_comps,
    input  logic o_valid,
    input  logic i_ready,
    input  t_pose o_comps,
    input  logic [1:0] o_anim_status,
    input  logic o_pose_written,
    input  logic o_rejected,
    output int fail_count,
    output int pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_pose pose;
        logic [1:0] status;
        logic wrote;
        logic rej;
    } t_pose_result;

    logic [15:0] frames [KEYS];
    t_pose comps [KEYS];
    int count;
    t_pose start_pose;
    t_pose held;
    logic [15:0] frame_ctr;
    int target;
    logic from_start;
    logic [1:0] play;
    t_pose_result pending_results[$];

    assign pending_count = pending_results.size();

    function automatic logic signed [31:0] lerp_comp(logic signed [31:0] a,
                                                     logic signed [31:0] b,
                                                     longint t);
        longint p;
        longint r;
        p = (longint'(b) - longint'(a)) * t;
        r = longint'(a) + (p >>> FRAC_BITS);
        return r[31:0];
    endfunction

    function automatic logic advance_frame();
        t_pose prev;
        longint pf, cf, i, d, t, one;
        logic wrote;
        wrote = 1'b0;
        one = longint'(1) << FRAC_BITS;
        if (target >= count) begin
            play = ST_FINISHED;
        end else begin
            cf = longint'(frames[target]);
            if (from_start || target == 0) begin
                prev = start_pose;
                pf = longint'(0);
            end else begin
                prev = comps[target-1];
                pf = longint'(frames[target-1]);
            end
            if (longint'(frame_ctr) < cf) begin
                i = longint'(frame_ctr) - pf;
                d = cf - pf - longint'(1);
                if (d <= 0) t = one;
                else if (i <= 0) t = longint'(0);
                else t = (i * one) / d;
                if (t > one) t = one;
                for (int k = 0; k < NCOMP; k++)
                    held[k] = lerp_comp(prev[k], comps[target][k], t);
                wrote = 1'b1;
            end else if (target + 1 < count) begin
                from_start = 1'b0;
                target++;
            end else begin
                play = ST_FINISHED;
            end
        end
        frame_ctr = frame_ctr + 16'd1;
        return wrote;
    endfunction

    function automatic t_pose_result apply_request(logic [2:0] kind, logic [15:0] kf,
                                                   logic [3:0] di, t_pose c);
        t_pose_result r;
        int pos;
        r.wrote = 1'b0;
        r.rej = 1'b0;
        case (kind)
            K_TICK: if (play == ST_PLAYING) r.wrote = advance_frame();
            K_INSERT: begin
                if (count >= KEYS) begin
                    r.rej = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < count && frames[pos] <= kf) pos++;
                    for (int j = count; j > pos; j--) begin
                        frames[j] = frames[j-1];
                        comps[j] = comps[j-1];
                    end
                    frames[pos] = kf;
                    comps[pos] = c;
                    count++;
                end
            end
            K_SETSTART: start_pose = c;
            K_DELETE: begin
                if (int'(di) >= count) begin
                    r.rej = 1'b1;
                end else begin
                    for (int j = int'(di); j + 1 < count; j++) begin
                        frames[j] = frames[j+1];
                        comps[j] = comps[j+1];
                    end
                    count--;
                end
            end
            K_CLEAR: count = 0;
            K_START: begin
                if (count >= 2 && play == ST_FINISHED) begin
                    target = 0;
                    from_start = 1'b1;
                    frame_ctr = '0;
                    play = ST_PLAYING;
                end else if (play == ST_PAUSED) begin
                    play = ST_PLAYING;
                end
            end
            K_PAUSE: play = ST_PAUSED;
            default: begin
                frame_ctr = '0;
                target = 0;
                from_start = 1'b1;
                held = start_pose;
                r.wrote = 1'b1;
                play = ST_FINISHED;
            end
        endcase
        r.pose = held;
        r.status = play;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pose_result e;
        t_pose_result got;
        if (!i_rst_n) begin
            count <= 0;
            start_pose <= '0;
            held <= '0;
            frame_ctr <= '0;
            target <= 0;
            from_start <= 1'b1;
            play <= ST_FINISHED;
            fail_count <= 0;
            pending_results.delete();
        end else begin
            if (i_valid && o_ready)
                pending_results.insert(pending_results.size(),
                                       apply_request(i_kind, i_key_frame_number,
                                                     i_delete_index, i_comps));
            if (o_valid && i_ready) begin
                got = {o_comps, o_anim_status, o_pose_written, o_rejected};
                if (pending_results.size() == 0) begin
                    if (fail_count < 10) $display("Result with no request pending");
                    fail_count <= fail_count + 1;
                end else begin
                    e = pending_results.pop_front();
                    if (got !== e) begin
                        if (fail_count < 10)
                            $display("Bad result: expected %h got %h", e, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: test/tb_keyframe_pose_interpolator_top.sv
module tb_keyframe_pose_interpolator_top;
    import kpi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [2:0] i_kind = K_TICK;
    logic [15:0] i_key_frame_number = '0;
    logic [3:0] i_delete_index = '0;
    t_pose i_comps = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_pose o_comps;
    logic [1:0] o_anim_status;
    logic o_pose_written;
    logic o_rejected;
    int fail_count;
    int pending_count;
    int burst_left;
    int key_total;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    keyframe_pose_interpolator_top i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_key_frame_number,
        .i_delete_index,
        .i_pos_x(i_comps[0]), .i_pos_y(i_comps[1]), .i_pos_z(i_comps[2]),
        .i_scale_x(i_comps[3]), .i_scale_y(i_comps[4]), .i_scale_z(i_comps[5]),
        .i_rot_x(i_comps[6]), .i_rot_y(i_comps[7]), .i_rot_z(i_comps[8]),
        .o_valid, .i_ready,
        .o_out_pos_x(o_comps[0]), .o_out_pos_y(o_comps[1]), .o_out_pos_z(o_comps[2]),
        .o_out_scale_x(o_comps[3]), .o_out_scale_y(o_comps[4]),
        .o_out_scale_z(o_comps[5]),
        .o_out_rot_x(o_comps[6]), .o_out_rot_y(o_comps[7]), .o_out_rot_z(o_comps[8]),
        .o_anim_status, .o_pose_written, .o_rejected
    );

    keyframe_pose_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_key_frame_number,
        .i_delete_index, .i_comps, .o_valid, .i_ready, .o_comps, .o_anim_status,
        .o_pose_written, .o_rejected, .fail_count, .pending_count
    );

    always @(posedge i_clk) begin
        int phase;
        phase = $urandom_range(0, 99);
        if (!i_rst_n) i_ready <= 1'b0;
        else if ($time < 2000000) i_ready <= (phase < 60);
        else i_ready <= 1'b1;
    end

    function automatic t_pose random_pose(int style);
        t_pose p;
        for (int k = 0; k < NCOMP; k++) begin
            case (style)
                0: p[k] = $urandom;
                1: p[k] = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
                default: p[k] = $signed($urandom_range(0, 2000000)) - 1000000;
            endcase
        end
        return p;
    endfunction

    task automatic send_request(logic [2:0] kind, logic [15:0] kf, logic [3:0] di,
                                t_pose c);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        key_total++;
        i_kind <= kind;
        i_key_frame_number <= kf;
        i_delete_index <= di;
        i_comps <= c;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (burst_left == 0) i_valid <= 1'b0;
    endtask

    task automatic play_sequence();
        int n;
        int m;
        send_request(K_RESET, '0, '0, '0);
        send_request(K_CLEAR, '0, '0, '0);
        send_request(K_SETSTART, '0, '0, random_pose($urandom_range(0, 2)));
        n = $urandom_range(2, 5);
        for (int i = 0; i < n; i++)
            send_request(K_INSERT, 16'($urandom_range(0, 12)), 4'($urandom),
                         random_pose($urandom_range(0, 2)));
        send_request(K_START, '0, '0, '0);
        m = $urandom_range(10, 40);
        for (int i = 0; i < m; i++) begin
            case ($urandom_range(0, 29))
                0: send_request(K_PAUSE, '0, '0, '0);
                1: send_request(K_START, '0, '0, '0);
                2: send_request(K_DELETE, '0, 4'($urandom_range(0, 5)), '0);
                3: send_request(K_INSERT, 16'($urandom_range(0, 20)), '0, random_pose(0));
                default: send_request(K_TICK, 16'($urandom), 4'($urandom), random_pose(0));
            endcase
        end
    endtask

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        burst_left = 0;
        key_total = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_request(K_TICK, '0, '0, '0);
        send_request(K_DELETE, '0, '0, '0);
        send_request(K_INSERT, 16'hffff, 4'hf, random_pose(1));
        send_request(K_INSERT, 16'h0000, '0, random_pose(1));
        send_request(K_INSERT, 16'h0000, '0, random_pose(0));
        send_request(K_SETSTART, '0, '0, random_pose(1));
        send_request(K_START, '0, '0, '0);
        send_request(K_TICK, '0, '0, '0);
        send_request(K_TICK, '0, '0, '0);
        send_request(K_PAUSE, '0, '0, '0);
        send_request(K_TICK, '0, '0, '0);
        send_request(K_START, '0, '0, '0);
        send_request(K_TICK, '0, '0, '0);
        send_request(K_DELETE, '0, 4'hf, '0);
        send_request(K_RESET, '0, '0, '0);
        send_request(K_CLEAR, '0, '0, '0);
        send_request(K_START, '0, '0, '0);
        for (int i = 0; i < 18; i++)
            send_request(K_INSERT, 16'($urandom), 4'($urandom), random_pose(0));
        send_request(K_DELETE, '0, 4'd15, '0);
        send_request(K_CLEAR, '0, '0, '0);
        while (key_total < 1300) begin
            if ($urandom_range(0, 9) < 8) begin
                play_sequence();
            end else begin
                send_request(3'($urandom), 16'($urandom), 4'($urandom), random_pose(0));
            end
        end
        i_valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
